/* src/rgbhsv_pkg.sv */
// Types and constants shared by the RGB to HSV converter and its checker.
package rgbhsv_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int HUE_BITS     = 13;
    localparam int HQ_BITS      = 10;
    localparam int HD_BITS      = CHANNEL_BITS + HQ_BITS;
    localparam int SD_BITS      = 2 * CHANNEL_BITS;
    localparam int DIV_STAGES   = (HQ_BITS > CHANNEL_BITS) ? HQ_BITS : CHANNEL_BITS;
    localparam int PIPE_LATENCY = DIV_STAGES + 4;

    localparam logic [HQ_BITS-1:0]  HUE_SECTOR     = HQ_BITS'(960);
    localparam logic [HUE_BITS-1:0] HUE_BASE_GREEN = HUE_BITS'(1920);
    localparam logic [HUE_BITS-1:0] HUE_BASE_BLUE  = HUE_BITS'(3840);
    localparam logic [HUE_BITS-1:0] HUE_TURN       = HUE_BITS'(5760);

    typedef logic [1:0] t_sector;
    localparam t_sector SECT_RED   = 2'd0;
    localparam t_sector SECT_GREEN = 2'd1;
    localparam t_sector SECT_BLUE  = 2'd2;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [HUE_BITS-1:0]     hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } t_hsv;

endpackage

/* src/rgb_to_hsv_converter_core.sv */
// RGB to HSV converter: a fully pipelined datapath taking one pixel per clock.
//
// One pixel may be started in every clock cycle. Its result appears on o_result with
// o_valid high for exactly one cycle, once it has passed the input, min/max and
// dividend stages, the two restoring dividers, which resolve up to one quotient bit
// per register stage, and the output stage. The receiver cannot stall the pipeline, so
// results must be taken when o_valid is high. busy is high only while reset is held
// and in the cycle it is released. Hue is in sixteenths of a degree; grey pixels give
// hue zero and black pixels give saturation zero.
module rgb_to_hsv_converter_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rgbhsv_pkg::t_pixel  i_pixel,
    output logic                o_valid,
    output rgbhsv_pkg::t_hsv    o_result
);

    localparam int CB   = rgbhsv_pkg::CHANNEL_BITS;
    localparam int HB   = rgbhsv_pkg::HUE_BITS;
    localparam int HQ   = rgbhsv_pkg::HQ_BITS;
    localparam int HD_W = rgbhsv_pkg::HD_BITS;
    localparam int SD_W = rgbhsv_pkg::SD_BITS;
    localparam int DS   = rgbhsv_pkg::DIV_STAGES;

    logic r_live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= 1'b1;
        end
    end

    assign busy = ~r_live;

    // Input register.
    logic               r_s1_valid;
    rgbhsv_pkg::t_pixel r_s1_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start & ~busy;
        end
        r_s1_pix <= i_pixel;
    end

    // Max, min, sector and signed channel difference.
    logic [CB-1:0]       n_mx;
    logic [CB-1:0]       n_mn;
    rgbhsv_pkg::t_sector n_sect;
    logic [CB:0]         n_diff;
    logic [CB-1:0]       n_mag;

    always_comb begin
        n_mx = r_s1_pix.red;
        if (r_s1_pix.green > n_mx) begin
            n_mx = r_s1_pix.green;
        end
        if (r_s1_pix.blue > n_mx) begin
            n_mx = r_s1_pix.blue;
        end
        n_mn = r_s1_pix.red;
        if (r_s1_pix.green < n_mn) begin
            n_mn = r_s1_pix.green;
        end
        if (r_s1_pix.blue < n_mn) begin
            n_mn = r_s1_pix.blue;
        end
        // Ties go to red, then green.
        if (n_mx == r_s1_pix.red) begin
            n_sect = rgbhsv_pkg::SECT_RED;
            n_diff = {1'b0, r_s1_pix.green} - {1'b0, r_s1_pix.blue};
        end else if (n_mx == r_s1_pix.green) begin
            n_sect = rgbhsv_pkg::SECT_GREEN;
            n_diff = {1'b0, r_s1_pix.blue} - {1'b0, r_s1_pix.red};
        end else begin
            n_sect = rgbhsv_pkg::SECT_BLUE;
            n_diff = {1'b0, r_s1_pix.red} - {1'b0, r_s1_pix.green};
        end
        n_mag = n_diff[CB] ? CB'(-n_diff) : n_diff[CB-1:0];
    end

    logic                r_s2_valid;
    logic [CB-1:0]       r_s2_mx;
    logic [CB-1:0]       r_s2_chr;
    rgbhsv_pkg::t_sector r_s2_sect;
    logic                r_s2_neg;
    logic [CB-1:0]       r_s2_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_mx   <= n_mx;
        r_s2_chr  <= n_mx - n_mn;
        r_s2_sect <= n_sect;
        r_s2_neg  <= n_diff[CB];
        r_s2_mag  <= n_mag;
    end

    // Divider pipeline. Index 0 holds the dividends; stage i+1 resolves one more hue quotient
    // bit, and a saturation bit where K < CB. A zero divisor yields junk that is masked later.
    logic                r_v    [0:DS];
    rgbhsv_pkg::t_sector r_sect [0:DS];
    logic                r_neg  [0:DS];
    logic [CB-1:0]       r_mx   [0:DS];
    logic [CB-1:0]       r_chr  [0:DS];
    logic [HD_W-1:0]     r_hrem [0:DS];
    logic [SD_W-1:0]     r_srem [0:DS];
    logic [HQ-1:0]       r_hq   [0:DS];
    logic [CB-1:0]       r_sq   [0:DS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_s2_valid;
        end
        r_sect[0] <= r_s2_sect;
        r_neg[0]  <= r_s2_neg;
        r_mx[0]   <= r_s2_mx;
        r_chr[0]  <= r_s2_chr;
        r_hrem[0] <= HD_W'(r_s2_mag) * HD_W'(rgbhsv_pkg::HUE_SECTOR);
        // Full-scale times chroma, as a shift and a subtract.
        r_srem[0] <= (SD_W'(r_s2_chr) << CB) - SD_W'(r_s2_chr);
        r_hq[0]   <= '0;
        r_sq[0]   <= '0;
    end

    for (genvar i = 0; i < DS; i++) begin : g_div
        localparam int K = DS - 1 - i;

        logic [HD_W-1:0] n_hrem;
        logic [HQ-1:0]   n_hq;
        logic [SD_W-1:0] n_srem;
        logic [CB-1:0]   n_sq;

        if (K < HQ) begin : g_hue
            logic [HD_W-1:0] n_hsh;
            assign n_hsh = HD_W'(r_chr[i]) << K;
            always_comb begin
                n_hrem = r_hrem[i];
                n_hq   = r_hq[i];
                if (r_hrem[i] >= n_hsh) begin
                    n_hrem = r_hrem[i] - n_hsh;
                    n_hq[K] = 1'b1;
                end
            end
        end else begin : g_hue_pass
            assign n_hrem = r_hrem[i];
            assign n_hq   = r_hq[i];
        end

        if (K < CB) begin : g_sat
            logic [SD_W-1:0] n_ssh;
            assign n_ssh = SD_W'(r_mx[i]) << K;
            always_comb begin
                n_srem = r_srem[i];
                n_sq   = r_sq[i];
                if (r_srem[i] >= n_ssh) begin
                    n_srem = r_srem[i] - n_ssh;
                    n_sq[K] = 1'b1;
                end
            end
        end else begin : g_sat_pass
            assign n_srem = r_srem[i];
            assign n_sq   = r_sq[i];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
            r_sect[i+1] <= r_sect[i];
            r_neg[i+1]  <= r_neg[i];
            r_mx[i+1]   <= r_mx[i];
            r_chr[i+1]  <= r_chr[i];
            r_hrem[i+1] <= n_hrem;
            r_srem[i+1] <= n_srem;
            r_hq[i+1]   <= n_hq;
            r_sq[i+1]   <= n_sq;
        end
    end

    // Hue assembly and special cases.
    logic [HB-1:0]    n_q;
    logic [HB-1:0]    n_hue;
    logic [CB-1:0]    n_sat;

    always_comb begin
        n_q = HB'(r_hq[DS]);
        case (r_sect[DS])
            rgbhsv_pkg::SECT_RED: begin
                // A negative offset that truncates to zero stays zero.
                n_hue = (r_neg[DS] && (n_q != '0)) ? (rgbhsv_pkg::HUE_TURN - n_q) : n_q;
            end
            rgbhsv_pkg::SECT_GREEN: begin
                n_hue = r_neg[DS] ? (rgbhsv_pkg::HUE_BASE_GREEN - n_q)
                                  : (rgbhsv_pkg::HUE_BASE_GREEN + n_q);
            end
            default: begin
                n_hue = r_neg[DS] ? (rgbhsv_pkg::HUE_BASE_BLUE - n_q)
                                  : (rgbhsv_pkg::HUE_BASE_BLUE + n_q);
            end
        endcase
        if (r_chr[DS] == '0) begin
            n_hue = '0;
        end
        n_sat = (r_mx[DS] == '0) ? '0 : r_sq[DS];
    end

    logic             r_out_valid;
    rgbhsv_pkg::t_hsv r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_v[DS];
        end
        r_out.hue        <= n_hue;
        r_out.saturation <= n_sat;
        r_out.brightness <= r_mx[DS];
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

/* src/rgbhsv_checker.sv */
// Port-level assertions for the RGB to HSV converter, bound to its top level.
module rgbhsv_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  rgbhsv_pkg::t_pixel i_pixel,
    input  logic               o_valid,
    input  rgbhsv_pkg::t_hsv   o_result
);

    localparam int LAT = rgbhsv_pkg::PIPE_LATENCY;

    // Every accepted transaction produces its result after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted transaction produced no result at fixed latency");

    // No result appears without a matching accepted transaction.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without a matching transaction");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.hue < rgbhsv_pkg::HUE_TURN))
        else $error("hue out of range");

    // Zero saturation means zero chroma, which must give zero hue.
    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.saturation == '0)) |-> (o_result.hue == '0))
        else $error("grey pixel with nonzero hue");

    // Brightness is the largest channel of the pixel that was accepted.
    a_value_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_result.brightness >= $past(i_pixel.red, LAT)) &&
                     (o_result.brightness >= $past(i_pixel.green, LAT)) &&
                     (o_result.brightness >= $past(i_pixel.blue, LAT)) &&
                     ((o_result.brightness == $past(i_pixel.red, LAT)) ||
                      (o_result.brightness == $past(i_pixel.green, LAT)) ||
                      (o_result.brightness == $past(i_pixel.blue, LAT)))))
        else $error("brightness is not the largest channel");

endmodule

bind rgb_to_hsv_converter_core rgbhsv_checker u_rgbhsv_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_pixel  (i_pixel),
    .o_valid  (o_valid),
    .o_result (o_result)
);

/* verif/tb_rgb_to_hsv_converter_core.sv */
// Self-checking testbench for the pipelined RGB to HSV converter core.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_core;

    localparam int CLK_HALF     = 5;
    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_LIMIT   = 1000;
    localparam int CB           = rgbhsv_pkg::CHANNEL_BITS;
    localparam int CHAN_MAX     = (1 << CB) - 1;
    localparam int MAX_REPORTS  = 10;

    // Holds predicted HSV results in acceptance order and compares the pipeline output.
    class hsv_checker;
        rgbhsv_pkg::t_hsv expected_hsv[$];
        int   mismatches;
        int   pixels_seen;
        int   results_seen;
        int   grey_hits;
        int   black_hits;
        int   sector_hits[3];

        function rgbhsv_pkg::t_hsv predict_hsv(rgbhsv_pkg::t_pixel px,
                                               output rgbhsv_pkg::t_sector sect);
            int               r, g, b, mx, mn, chroma, diff, base, quot, hue;
            rgbhsv_pkg::t_hsv res;
            r = px.red;
            g = px.green;
            b = px.blue;
            mx = r;
            mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            chroma = mx - mn;
            hue = 0;
            // Ties on the maximum resolve to red first, then green.
            if (mx == r) begin
                sect = rgbhsv_pkg::SECT_RED;
                diff = g - b;
                base = 0;
            end else if (mx == g) begin
                sect = rgbhsv_pkg::SECT_GREEN;
                diff = b - r;
                base = int'(rgbhsv_pkg::HUE_BASE_GREEN);
            end else begin
                sect = rgbhsv_pkg::SECT_BLUE;
                diff = r - g;
                base = int'(rgbhsv_pkg::HUE_BASE_BLUE);
            end
            if (chroma != 0) begin
                quot = (int'(rgbhsv_pkg::HUE_SECTOR) * ((diff < 0) ? -diff : diff)) / chroma;
                hue = base + ((diff < 0) ? -quot : quot);
                if (hue < 0) hue += int'(rgbhsv_pkg::HUE_TURN);
            end
            res.hue        = rgbhsv_pkg::HUE_BITS'(hue);
            res.saturation = (mx != 0) ? CB'((CHAN_MAX * chroma) / mx) : '0;
            res.brightness = CB'(mx);
            return res;
        endfunction

        function void note_pixel(rgbhsv_pkg::t_pixel px);
            rgbhsv_pkg::t_sector sect;
            rgbhsv_pkg::t_hsv    res;
            res = predict_hsv(px, sect);
            expected_hsv.push_back(res);
            pixels_seen++;
            if (res.brightness == 0) black_hits++;
            if (px.red == px.green && px.green == px.blue) grey_hits++;
            else sector_hits[sect]++;
        endfunction

        function void check_hsv(rgbhsv_pkg::t_hsv got);
            rgbhsv_pkg::t_hsv want;
            results_seen++;
            if (expected_hsv.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result hue=%0d sat=%0d val=%0d", $time,
                             got.hue, got.saturation, got.brightness);
                return;
            end
            want = expected_hsv.pop_front();
            if (got.hue !== want.hue || got.saturation !== want.saturation ||
                got.brightness !== want.brightness) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: mismatch hue %0d/%0d sat %0d/%0d val %0d/%0d (exp/got)",
                             $time, want.hue, got.hue, want.saturation, got.saturation,
                             want.brightness, got.brightness);
            end
        endfunction

        function int pending();
            return expected_hsv.size();
        endfunction
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    rgbhsv_pkg::t_pixel i_pixel = '0;
    logic               busy;
    logic               o_valid;
    rgbhsv_pkg::t_hsv   o_result;

    hsv_checker hsv_chk = new();
    int         burst_left = 0;
    int         idle_cycles = 0;

    rgb_to_hsv_converter_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_pixel  (i_pixel),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Monitors both sides and watches for a pipeline that has stopped moving.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) hsv_chk.note_pixel(i_pixel);
        if (i_rst_n && o_valid) hsv_chk.check_hsv(o_result);
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic rgbhsv_pkg::t_pixel random_pixel();
        rgbhsv_pkg::t_pixel px;
        int                 v, lo;
        px = rgbhsv_pkg::t_pixel'($urandom);
        v = $urandom_range(0, CHAN_MAX);
        case ($urandom_range(0, 9))
            0: begin
                px = '{CB'(v), CB'(v), CB'(v)};
            end
            1: begin
                // At least two channels share the maximum, so the sector tie rule decides.
                lo = $urandom_range(0, v);
                case ($urandom_range(0, 2))
                    0: px = '{CB'(v), CB'(v), CB'(lo)};
                    1: px = '{CB'(v), CB'(lo), CB'(v)};
                    default: px = '{CB'(lo), CB'(v), CB'(v)};
                endcase
            end
            2: begin
                // Small chroma stresses the quotient rounding.
                lo = (v > CHAN_MAX - 3) ? CHAN_MAX - 3 : v;
                px.red   = CB'(lo + $urandom_range(0, 3));
                px.green = CB'(lo + $urandom_range(0, 3));
                px.blue  = CB'(lo + $urandom_range(0, 3));
            end
            default: ;
        endcase
        return px;
    endfunction

    // Sends one pixel, inserting idle gaps between most bursts of back-to-back transactions.
    task automatic push_pixel(input rgbhsv_pkg::t_pixel px);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                start   <= 1'b0;
                i_pixel <= rgbhsv_pkg::t_pixel'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start   <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        rgbhsv_pkg::t_pixel corners[$] = '{
            '{8'd0,   8'd0,   8'd0  }, '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
            '{8'd255, 8'd0,   8'd0  }, '{8'd0,   8'd255, 8'd0  }, '{8'd0,   8'd0,   8'd255},
            '{8'd255, 8'd255, 8'd0  }, '{8'd255, 8'd0,   8'd255}, '{8'd0,   8'd255, 8'd255},
            '{8'd255, 8'd0,   8'd1  }, '{8'd255, 8'd1,   8'd0  }, '{8'd1,   8'd0,   8'd0  },
            '{8'd0,   8'd1,   8'd0  }, '{8'd0,   8'd0,   8'd1  }, '{8'd1,   8'd1,   8'd0  },
            '{8'd255, 8'd254, 8'd254}, '{8'd200, 8'd100, 8'd50 }, '{8'd50,  8'd200, 8'd100},
            '{8'd100, 8'd50,  8'd200}, '{8'd255, 8'd128, 8'd0  }, '{8'd1,   8'd255, 8'd0  },
            '{8'd0,   8'd254, 8'd255}, '{8'd170, 8'd85,  8'd255}
        };
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (corners[i]) push_pixel(corners[i]);
        repeat (RANDOM_ITEMS) push_pixel(random_pixel());
        start <= 1'b0;
        while (hsv_chk.pending() != 0) @(posedge i_clk);
        repeat (rgbhsv_pkg::PIPE_LATENCY + 6) @(posedge i_clk);
        $display("Converted %0d pixels, checked %0d results, %0d mismatches",
                 hsv_chk.pixels_seen, hsv_chk.results_seen, hsv_chk.mismatches);
        $display("Grey %0d, black %0d, red/green/blue sector %0d/%0d/%0d",
                 hsv_chk.grey_hits, hsv_chk.black_hits, hsv_chk.sector_hits[0],
                 hsv_chk.sector_hits[1], hsv_chk.sector_hits[2]);
        if (hsv_chk.mismatches == 0 && hsv_chk.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
